// File: rtl/core/assert_macros.svh
// Assertion helpers used by the RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// expr must hold at every clock edge outside reset
`define PMED_ASSERT(label, clk, rst, expr) \
  label: assert property (@(posedge clk) disable iff (rst) (expr)) \
    else $error("assertion failed");

// cons must hold in the cycle after ante
`define PMED_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

// File: rtl/core/pmed_pkg.sv
`default_nettype none
package pmed_pkg;

  localparam int MaxNodes     = 32;
  localparam int MaxMaskBytes = 8;
  localparam int IdW          = 32;
  localparam int MaskW        = 64;
  localparam int WidthW       = 4;
  localparam int NodeIdxW     = $clog2(MaxNodes);
  localparam int NodeCntW     = $clog2(MaxNodes + 1);

  typedef struct packed {
    logic [IdW-1:0]   id;
    logic [MaskW-1:0] mask;
  } entry_t;

  typedef struct packed {
    logic shift;
    logic insert;
  } chain_ctrl_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_DONE
  } state_t;

  // byte enables for the partition's mask width, saturated at MaxMaskBytes
  function automatic logic [MaskW-1:0] width_mask(input logic [WidthW-1:0] w);
    logic [MaskW-1:0] m;
    m = '0;
    for (int b = 0; b < MaxMaskBytes; b++) begin
      if (WidthW'(b) < w) begin
        m[8*b +: 8] = 8'hFF;
      end
    end
    return m;
  endfunction

endpackage
`default_nettype wire

// File: rtl/core/pmed_cell.sv
`default_nettype none
module pmed_cell (
  input  wire logic            clk,
  input  wire logic            shift,
  input  wire pmed_pkg::entry_t d,
  output pmed_pkg::entry_t     q
);

  always_ff @(posedge clk) begin
    if (shift) begin
      q <= d;
    end
  end

endmodule
`default_nettype wire

// File: rtl/core/pmed_ctrl.sv
`default_nettype none
`include "assert_macros.svh"
module pmed_ctrl (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          in_valid,
  output logic                               in_ready,
  input  wire logic [pmed_pkg::IdW-1:0]      node_id,
  input  wire logic [pmed_pkg::MaskW-1:0]    membership_mask,
  input  wire logic [pmed_pkg::WidthW-1:0]   mask_width,
  input  wire logic                          starts_partition,
  output logic                               out_valid,
  input  wire logic                          out_ready,
  output logic [pmed_pkg::IdW-1:0]           edge_from,
  output logic [pmed_pkg::IdW-1:0]           edge_to,
  output logic                               edge_valid,
  output logic                               overflow,
  output logic                               last_result,
  input  wire pmed_pkg::entry_t              head,
  output pmed_pkg::entry_t                   new_entry,
  output pmed_pkg::chain_ctrl_t              chain
);

  pmed_pkg::state_t                    state, state_next;
  logic [pmed_pkg::NodeIdxW-1:0]       step;
  logic [pmed_pkg::NodeCntW-1:0]       count;
  logic [pmed_pkg::NodeCntW-1:0]       count_eff;
  logic [pmed_pkg::IdW-1:0]            nid;
  logic [pmed_pkg::MaskW-1:0]          nmask;
  logic [pmed_pkg::MaskW-1:0]          wm;
  logic                                clique;
  logic                                ovf;
  logic                                pend_valid;
  logic [pmed_pkg::IdW-1:0]            pend_id;
  logic                                accept;
  logic                                head_in_use;
  logic                                head_hit;
  logic                                out_free;
  logic                                stall;
  logic                                push_mid;
  logic                                push_fin;

  assign accept      = in_valid && in_ready;
  assign count_eff   = starts_partition ? '0 : count;
  assign head_in_use = pmed_pkg::NodeCntW'(step) < count;
  assign out_free    = !out_valid || out_ready;
  assign new_entry   = '{id: nid, mask: nmask};

  always_comb begin
    state_next = state;
    unique case (state)
      pmed_pkg::ST_IDLE: begin
        if (in_valid) begin
          state_next = (count_eff == pmed_pkg::NodeCntW'(pmed_pkg::MaxNodes)) ?
                       pmed_pkg::ST_DONE : pmed_pkg::ST_SCAN;
        end
      end
      pmed_pkg::ST_SCAN: begin
        if (chain.shift && step == pmed_pkg::NodeIdxW'(pmed_pkg::MaxNodes - 1)) begin
          state_next = pmed_pkg::ST_DONE;
        end
      end
      pmed_pkg::ST_DONE: begin
        if (out_free) begin
          state_next = pmed_pkg::ST_IDLE;
        end
      end
      default: state_next = pmed_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    in_ready     = 1'b0;
    head_hit     = 1'b0;
    stall        = 1'b0;
    chain.shift  = 1'b0;
    chain.insert = 1'b0;
    push_mid     = 1'b0;
    push_fin     = 1'b0;
    unique case (state)
      pmed_pkg::ST_IDLE: begin
        in_ready = 1'b1;
      end
      pmed_pkg::ST_SCAN: begin
        head_hit     = head_in_use && (clique || (|(head.mask & nmask & wm)));
        stall        = head_hit && pend_valid && !out_free;
        chain.shift  = !stall;
        chain.insert = !stall && (pmed_pkg::NodeCntW'(step) == count);
        push_mid     = !stall && head_hit && pend_valid;
      end
      pmed_pkg::ST_DONE: begin
        push_fin = out_free;
      end
      default: begin
        in_ready = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= pmed_pkg::ST_IDLE;
      count      <= '0;
      step       <= '0;
      pend_valid <= 1'b0;
      ovf        <= 1'b0;
      out_valid  <= 1'b0;
    end else begin
      state <= state_next;
      if (accept) begin
        count      <= count_eff;
        step       <= '0;
        pend_valid <= 1'b0;
        ovf        <= (count_eff == pmed_pkg::NodeCntW'(pmed_pkg::MaxNodes));
      end else begin
        if (chain.shift) begin
          step <= step + 1'b1;
          if (head_hit) begin
            pend_valid <= 1'b1;
          end
        end
        if (push_fin && !ovf) begin
          count <= count + 1'b1;
        end
      end
      if (push_mid || push_fin) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      nid    <= node_id;
      nmask  <= membership_mask;
      wm     <= pmed_pkg::width_mask(mask_width);
      clique <= (mask_width == '0);
    end
    if (chain.shift && head_hit) begin
      pend_id <= head.id;
    end
    if (push_mid) begin
      edge_from   <= nid;
      edge_to     <= pend_id;
      edge_valid  <= 1'b1;
      overflow    <= 1'b0;
      last_result <= 1'b0;
    end else if (push_fin) begin
      edge_from   <= nid;
      edge_to     <= (pend_valid && !ovf) ? pend_id : '0;
      edge_valid  <= pend_valid && !ovf;
      overflow    <= ovf;
      last_result <= 1'b1;
    end
  end

  `PMED_ASSERT(a_count_range, clk, rst, count <= pmed_pkg::NodeCntW'(pmed_pkg::MaxNodes))
  `PMED_ASSERT(a_scan_has_room, clk, rst, state != pmed_pkg::ST_SCAN || count < pmed_pkg::NodeCntW'(pmed_pkg::MaxNodes))
  `PMED_ASSERT_NEXT(a_final_marked, clk, rst, push_fin, out_valid && last_result)
  `PMED_ASSERT_NEXT(a_accept_clears_pend, clk, rst, accept, !pend_valid && step == '0)

endmodule
`default_nettype wire

// File: rtl/core/partition_mask_edge_decoder_top.sv
// Partition mask edge decoder.
// Input channel (in_valid/in_ready): one node per transaction with node_id,
// membership_mask, mask_width and starts_partition. Output channel
// (out_valid/out_ready): edge results, last_result set on the final result
// of each input node. The stored nodes sit in a ring of MaxNodes cells that
// rotates one cell per cycle, unless stalled, past a single comparator at its head.
// An input is taken only while the block is idle. A normal node then rotates
// the ring through all MaxNodes cells, then issues its final result; a dropped
// node (store full) goes straight to its final result. A found edge is held
// back one match so last_result can be set: it is registered into the output
// register when the next matching stored node reaches the head and the output
// register is free. While the receiver stalls, a found edge waits in a pending
// register and the ring halts on the next match until the output register
// frees. Reset clears the node count and the control state; cell contents are
// not cleared and are only read below the count.
`default_nettype none
module partition_mask_edge_decoder_top (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic [31:0] node_id,
  input  wire logic [63:0] membership_mask,
  input  wire logic [3:0]  mask_width,
  input  wire logic        starts_partition,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic [31:0]      edge_from,
  output logic [31:0]      edge_to,
  output logic             edge_valid,
  output logic             overflow,
  output logic             last_result
);

  pmed_pkg::entry_t      cell_q [pmed_pkg::MaxNodes];
  pmed_pkg::entry_t      cell_d [pmed_pkg::MaxNodes];
  pmed_pkg::entry_t      new_entry;
  pmed_pkg::chain_ctrl_t chain;

  pmed_ctrl u_ctrl (
    .clk              (clk),
    .rst              (rst),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .node_id          (node_id),
    .membership_mask  (membership_mask),
    .mask_width       (mask_width),
    .starts_partition (starts_partition),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .edge_from        (edge_from),
    .edge_to          (edge_to),
    .edge_valid       (edge_valid),
    .overflow         (overflow),
    .last_result      (last_result),
    .head             (cell_q[0]),
    .new_entry        (new_entry),
    .chain            (chain)
  );

  for (genvar k = 0; k < pmed_pkg::MaxNodes; k++) begin : g_cell
    if (k == pmed_pkg::MaxNodes - 1) begin : g_tail
      assign cell_d[k] = chain.insert ? new_entry : cell_q[0];
    end else begin : g_body
      assign cell_d[k] = cell_q[k+1];
    end
    pmed_cell u_cell (
      .clk   (clk),
      .shift (chain.shift),
      .d     (cell_d[k]),
      .q     (cell_q[k])
    );
  end

endmodule
`default_nettype wire

// File: verif/partition_mask_edge_decoder_top_tb.sv
`timescale 1ns / 1ps

module partition_mask_edge_decoder_top_tb;

  localparam int CycleLimit = 1000000;
  localparam int TailCycles = 40;
  localparam int HoldCycles = 400;

  typedef struct {
    logic [pmed_pkg::IdW-1:0]    id;
    logic [pmed_pkg::MaskW-1:0]  mask;
    logic [pmed_pkg::WidthW-1:0] width;
    logic                        start;
    logic                        drain;
  } node_t;

  typedef struct {
    logic [pmed_pkg::IdW-1:0] from_id;
    logic [pmed_pkg::IdW-1:0] to_id;
    logic                     is_edge;
    logic                     ovf;
    logic                     last;
  } edge_res_t;

  logic                        clk = 1'b0;
  logic                        rst = 1'b1;
  logic                        in_valid = 1'b0;
  logic                        in_ready;
  logic [pmed_pkg::IdW-1:0]    node_id = '0;
  logic [pmed_pkg::MaskW-1:0]  membership_mask = '0;
  logic [pmed_pkg::WidthW-1:0] mask_width = '0;
  logic                        starts_partition = 1'b0;
  logic                        out_valid;
  logic                        out_ready = 1'b0;
  logic [pmed_pkg::IdW-1:0]    edge_from;
  logic [pmed_pkg::IdW-1:0]    edge_to;
  logic                        edge_valid;
  logic                        overflow;
  logic                        last_result;

  node_t     pend_nodes[$];
  edge_res_t edge_q[$];
  node_t     cur = '{default: '0};

  logic [pmed_pkg::IdW-1:0]   part_ids[pmed_pkg::MaxNodes];
  logic [pmed_pkg::MaskW-1:0] part_masks[pmed_pkg::MaxNodes];
  int                         part_count = 0;

  int  err_cnt = 0;
  int  acc_cnt = 0;
  int  cycles = 0;
  int  burst_left = 0;
  int  gap_left = 0;
  int  run_left = 0;
  int  hold_left = 0;
  bit  hold_done = 1'b0;
  logic nv;
  logic rdy;

  partition_mask_edge_decoder_top u_top (
    .clk              (clk),
    .rst              (rst),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .node_id          (node_id),
    .membership_mask  (membership_mask),
    .mask_width       (mask_width),
    .starts_partition (starts_partition),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .edge_from        (edge_from),
    .edge_to          (edge_to),
    .edge_valid       (edge_valid),
    .overflow         (overflow),
    .last_result      (last_result)
  );

  always #4 clk = ~clk;

  function automatic logic [pmed_pkg::MaskW-1:0] byte_enables(
      input logic [pmed_pkg::WidthW-1:0] w);
    logic [pmed_pkg::MaskW-1:0] m;
    m = '0;
    for (int b = 0; b < pmed_pkg::MaxMaskBytes; b++) begin
      if (b < w) begin
        m[8*b +: 8] = 8'hFF;
      end
    end
    return m;
  endfunction

  task automatic report(input string msg);
    if (err_cnt < 100) begin
      $display("[%0t] ERROR %s", $realtime, msg);
    end
    err_cnt++;
  endtask

  // expected results for one node transaction
  task automatic decode_node(input node_t nd);
    logic [pmed_pkg::MaskW-1:0] wm;
    int                         hits;
    wm = byte_enables(nd.width);
    hits = 0;
    if (nd.start) begin
      part_count = 0;
    end
    if (part_count >= pmed_pkg::MaxNodes) begin
      edge_q.push_back('{nd.id, '0, 1'b0, 1'b1, 1'b1});
    end else begin
      for (int i = 0; i < part_count; i++) begin
        if (nd.width == 0 || (nd.mask & part_masks[i] & wm) != '0) begin
          edge_q.push_back('{nd.id, part_ids[i], 1'b1, 1'b0, 1'b0});
          hits++;
        end
      end
      part_ids[part_count] = nd.id;
      part_masks[part_count] = nd.mask;
      part_count++;
      if (hits == 0) begin
        edge_q.push_back('{nd.id, '0, 1'b0, 1'b0, 1'b1});
      end else begin
        edge_q[edge_q.size()-1].last = 1'b1;
      end
    end
  endtask

  task automatic add_node(input logic [pmed_pkg::IdW-1:0] id,
                          input logic [pmed_pkg::MaskW-1:0] mask,
                          input int w, input bit start, input bit drain = 1'b0);
    node_t nd;
    nd.id = id;
    nd.mask = mask;
    nd.width = pmed_pkg::WidthW'(w);
    nd.start = start;
    nd.drain = drain;
    pend_nodes.push_back(nd);
  endtask

  function automatic logic [pmed_pkg::MaskW-1:0] rand_mask(input int w);
    logic [pmed_pkg::MaskW-1:0] m;
    int                         eff;
    int                         sel;
    eff = (w == 0 || w > pmed_pkg::MaxMaskBytes) ? pmed_pkg::MaxMaskBytes : w;
    sel = $urandom_range(0, 5);
    m = '0;
    if (sel == 0) begin
      m = {$urandom, $urandom};
    end else if (sel != 1) begin
      for (int k = 0; k < $urandom_range(1, 2); k++) begin
        m[$urandom_range(0, 8*eff-1)] = 1'b1;
      end
      if ($urandom_range(0, 3) == 0) begin
        m = m | ({$urandom, $urandom} & ~byte_enables(pmed_pkg::WidthW'(eff)));
      end
    end
    return m;
  endfunction

  // driver
  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      nv = in_valid;
      if (in_valid && in_ready) begin
        decode_node(cur);
        acc_cnt++;
        nv = 1'b0;
      end
      if (!nv) begin
        if (gap_left > 0) begin
          gap_left--;
        end else if (pend_nodes.size() != 0 &&
                     !(pend_nodes[0].drain && edge_q.size() != 0)) begin
          cur = pend_nodes.pop_front();
          nv = 1'b1;
          if (burst_left > 1) begin
            burst_left--;
          end else begin
            burst_left = $urandom_range(1, 8);
            gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 40);
          end
        end
      end
      in_valid <= nv;
      node_id <= cur.id;
      membership_mask <= cur.mask;
      mask_width <= cur.width;
      starts_partition <= cur.start;
    end
  end

  // receiver stall pattern, with one long hold-off
  always @(posedge clk) begin
    if (rst) begin
      out_ready <= 1'b0;
    end else begin
      if (hold_left > 0) begin
        hold_left--;
        rdy = 1'b0;
      end else if (!hold_done && acc_cnt >= 60) begin
        hold_done = 1'b1;
        hold_left = HoldCycles;
        rdy = 1'b0;
      end else if (run_left > 0) begin
        run_left--;
        rdy = out_ready;
      end else begin
        rdy = !out_ready;
        if (rdy) begin
          run_left = ($urandom_range(0, 4) == 0) ? 150 : $urandom_range(1, 12);
        end else begin
          run_left = $urandom_range(1, 6);
        end
      end
      out_ready <= rdy;
    end
  end

  // monitor
  always @(posedge clk) begin
    if (!rst && out_valid && out_ready) begin
      if (edge_q.size() == 0) begin
        report($sformatf("unexpected result from %0h to %0h", edge_from, edge_to));
      end else begin
        edge_res_t e;
        e = edge_q.pop_front();
        if (edge_from !== e.from_id)
          report($sformatf("edge_from got %0h want %0h", edge_from, e.from_id));
        if (edge_to !== e.to_id)
          report($sformatf("edge_to got %0h want %0h", edge_to, e.to_id));
        if (edge_valid !== e.is_edge)
          report($sformatf("edge_valid got %0b want %0b", edge_valid, e.is_edge));
        if (overflow !== e.ovf)
          report($sformatf("overflow got %0b want %0b", overflow, e.ovf));
        if (last_result !== e.last)
          report($sformatf("last_result got %0b want %0b", last_result, e.last));
      end
    end
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CycleLimit) begin
      $display("partition_mask_edge_decoder_top: mismatch");
      $finish;
    end
  end

  initial begin
    int          rand_cnt;
    int          plen;
    int          pw;
    int          w;
    bit          noise;
    bit          st;
    logic [31:0] id;
    logic [31:0] last_id;

    // directed
    add_node(32'h0, 64'h0, 0, 1'b0);
    add_node(32'hFFFF_FFFF, 64'hFFFF_FFFF_FFFF_FFFF, 0, 1'b0);
    add_node(32'h1, 64'hFFFF_FFFF_FFFF_FFFF, 8, 1'b1);
    add_node(32'h2, 64'h8000_0000_0000_0000, 8, 1'b0);
    add_node(32'h3, 64'h0, 8, 1'b0);
    add_node(32'h4, 64'h1, 15, 1'b0);
    add_node(32'h5, 64'h8000_0000_0000_0000, 9, 1'b0);
    add_node(32'h10, 64'hFF00, 2, 1'b1);
    add_node(32'h11, 64'hFF00, 1, 1'b0);
    add_node(32'h12, 64'h0100, 2, 1'b0);
    add_node(32'h20, 64'hFF00_0000_0000_0001, 1, 1'b1);
    add_node(32'h21, 64'hFF00_0000_0000_0002, 1, 1'b0);
    add_node(32'h21, 64'h2, 1, 1'b0);
    add_node(32'h30, 64'h0, 0, 1'b1);
    add_node(32'h31, 64'h0, 0, 1'b0);
    add_node(32'h32, 64'h0000_00FF_0000_0000, 4, 1'b0);
    add_node(32'h33, 64'h0000_0001_0000_0000, 5, 1'b0);
    add_node(32'hAAAA_5555, 64'h5555_AAAA_5555_AAAA, 8, 1'b1);
    add_node(32'h5555_AAAA, 64'hAAAA_5555_AAAA_5555, 8, 1'b0);

    // full clique partition, then overflow
    rand_cnt = 0;
    for (int k = 0; k < pmed_pkg::MaxNodes + 2; k++) begin
      add_node($urandom, rand_mask(0), 0, k == 0, k == 0);
      rand_cnt++;
    end

    last_id = '0;
    while (rand_cnt < 360) begin
      plen = ($urandom_range(0, 11) == 0) ?
             $urandom_range(pmed_pkg::MaxNodes + 1, pmed_pkg::MaxNodes + 4) :
             $urandom_range(1, 10);
      case ($urandom_range(0, 9))
        0: pw = 0;
        1: pw = $urandom_range(9, 15);
        default: pw = $urandom_range(1, 8);
      endcase
      noise = ($urandom_range(0, 9) == 0);
      for (int k = 0; k < plen; k++) begin
        w = ($urandom_range(0, 15) == 0) ? $urandom_range(0, 15) : pw;
        id = ($urandom_range(0, 9) == 0) ? last_id : $urandom;
        st = (k == 0) ? !noise : ($urandom_range(0, 40) == 0);
        add_node(id, rand_mask(w), w, st, k == 0 && $urandom_range(0, 7) == 0);
        last_id = id;
        rand_cnt++;
      end
    end

    repeat (8) @(posedge clk);
    rst <= 1'b0;

    while (pend_nodes.size() != 0 || in_valid) @(posedge clk);
    while (edge_q.size() != 0) @(posedge clk);
    repeat (TailCycles) @(posedge clk);

    if (err_cnt == 0 && edge_q.size() == 0) begin
      $display("partition_mask_edge_decoder_top: match");
    end else begin
      $display("partition_mask_edge_decoder_top: mismatch");
    end
    $finish;
  end

endmodule
